[rtl/core/hsv2rgb_pkg.sv]
// shared constants, types and helpers of the hsv to rgb converter
package hsv2rgb_pkg;

	// hue wrap: hue + 32768 + HUE_BIAS is a non-negative multiple-of-360 shift
	localparam int unsigned HUE_BIAS    = 352;
	localparam int unsigned HUE_RANGE   = 360;
	// floor(2^24 / 360), quotient estimate is low by at most one
	localparam int unsigned RECIP_360   = 46603;
	localparam int unsigned RECIP_360_SH = 24;

	localparam int unsigned SECTOR_SPAN = 60;
	localparam int unsigned UNIT_ONE    = 256;
	localparam int unsigned FULL_SCALE  = UNIT_ONE * SECTOR_SPAN;
	localparam int unsigned CHAN_SCALE  = 255;
	// ceil(2^16 / 15), exact for the quotient range used here
	localparam int unsigned RECIP_15    = 4370;

	localparam int unsigned REG_W   = 9;
	localparam int unsigned HUE_W   = 16;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned REM_W   = 6;
	localparam int unsigned IDX_W   = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_SAT = 2'd0,
		REG_BRI = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

	// limit a q.8 register value to 1.0
	function automatic logic [REG_W-1:0] clamp_unit(input logic [REG_W-1:0] x);
		logic [REG_W-1:0] r;
		r = (x > REG_W'(UNIT_ONE)) ? REG_W'(UNIT_ONE) : x;
		return r;
	endfunction

endpackage

[rtl/core/hsv_to_rgb_converter.sv]
// hsv to rgb converter: seven-stage pipeline from hue beat to rgb beat
// throughput: one beat per cycle; every stage advances together, held while rgb is stalled
// stages: hue wrap (3), channel multiply and divide by 60 (3), sector mapping (1)
// reset: arst_n clears valid bits, saturation and brightness return to 1.0
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  logic [HUE_W-1:0]  hue_in,
	output logic              rgb_valid,
	input  logic              rgb_stall,
	output logic [CHAN_W-1:0] red,
	output logic [CHAN_W-1:0] green,
	output logic [CHAN_W-1:0] blue,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]  cfg_data
);

	logic              adv;
	logic [6:0]        vld_q;
	logic [REG_W-1:0]  sat_q;
	logic [REG_W-1:0]  bri_q;
	sector_t           sector_s3;
	sector_t           sector_s4;
	sector_t           sector_s5;
	sector_t           sector_s6;
	logic [REM_W-1:0]  rem_s3;
	logic [REM_W-1:0]  k_t;
	logic [CHAN_W-1:0] cv_s6;
	logic [CHAN_W-1:0] cp_s6;
	logic [CHAN_W-1:0] cq_s6;
	logic [CHAN_W-1:0] ct_s6;
	logic [CHAN_W-1:0] red_s7;
	logic [CHAN_W-1:0] green_s7;
	logic [CHAN_W-1:0] blue_s7;
	logic [CHAN_W-1:0] red_d;
	logic [CHAN_W-1:0] green_d;
	logic [CHAN_W-1:0] blue_d;

	// whole pipe moves unless the output beat is held
	assign adv       = !rgb_valid || !rgb_stall;
	assign pix_stall = !adv;
	assign cfg_ready = 1'b1;

	// configuration registers, clamped to 1.0 on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= REG_W'(UNIT_ONE);
			bri_q <= REG_W'(UNIT_ONE);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SAT: sat_q <= clamp_unit(cfg_data);
				REG_BRI: bri_q <= clamp_unit(cfg_data);
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[5:0], pix_valid};
		end
	end

	assign rgb_valid = vld_q[6];

	// hue wrap and sector split
	hsv2rgb_hue u_hue (
		.clk       (clk),
		.adv       (adv),
		.hue       (hue_in),
		.sector_s3 (sector_s3),
		.rem_s3    (rem_s3)
	);

	assign k_t = REM_W'(SECTOR_SPAN) - rem_s3;

	// the four candidate channel values
	hsv2rgb_chan u_chan_v (
		.clk (clk), .adv (adv), .k ('0), .sat (sat_q), .bri (bri_q), .chan_s6 (cv_s6)
	);
	hsv2rgb_chan u_chan_p (
		.clk (clk), .adv (adv), .k (REM_W'(SECTOR_SPAN)), .sat (sat_q), .bri (bri_q),
		.chan_s6 (cp_s6)
	);
	hsv2rgb_chan u_chan_q (
		.clk (clk), .adv (adv), .k (rem_s3), .sat (sat_q), .bri (bri_q), .chan_s6 (cq_s6)
	);
	hsv2rgb_chan u_chan_t (
		.clk (clk), .adv (adv), .k (k_t), .sat (sat_q), .bri (bri_q), .chan_s6 (ct_s6)
	);

	// sector follows the channel stages
	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s4 <= sector_s3;
			sector_s5 <= sector_s4;
			sector_s6 <= sector_s5;
		end
	end

	// six-sector mapping
	always_comb begin
		unique case (sector_s6)
			SEC_1: begin red_d = cq_s6; green_d = cv_s6; blue_d = cp_s6; end
			SEC_2: begin red_d = cp_s6; green_d = cv_s6; blue_d = ct_s6; end
			SEC_3: begin red_d = cp_s6; green_d = cq_s6; blue_d = cv_s6; end
			SEC_4: begin red_d = ct_s6; green_d = cp_s6; blue_d = cv_s6; end
			SEC_5: begin red_d = cv_s6; green_d = cp_s6; blue_d = cq_s6; end
			default: begin red_d = cv_s6; green_d = ct_s6; blue_d = cp_s6; end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			red_s7   <= red_d;
			green_s7 <= green_d;
			blue_s7  <= blue_d;
		end
	end

	assign red   = red_s7;
	assign green = green_s7;
	assign blue  = blue_s7;

	// remainder of a live beat stays inside its sector
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] |-> (rem_s3 < REM_W'(SECTOR_SPAN)))
		else $error("hue remainder out of range");

	// sector of a live beat is one of six
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] |-> (3'(sector_s3) <= 3'(SEC_5)))
		else $error("hue sector out of range");

	// registers never exceed 1.0 after a write
	a_cfg_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=>
			(sat_q <= REG_W'(UNIT_ONE)) && (bri_q <= REG_W'(UNIT_ONE)))
		else $error("configuration register above unit");

endmodule

[rtl/core/hsv2rgb_hue.sv]
// hue wrap modulo 360 and split into sector and remainder, three stages
module hsv2rgb_hue import hsv2rgb_pkg::*; (
	input  logic              clk,
	input  logic              adv,
	input  logic [HUE_W-1:0]  hue,
	output sector_t           sector_s3,
	output logic [REM_W-1:0]  rem_s3
);

	logic [16:0] u;
	logic [32:0] qprod;
	logic [16:0] u_s1;
	logic [7:0]  qhat_s1;
	logic [9:0]  r0;
	logic [8:0]  h;
	logic [8:0]  h_s2;
	sector_t     sec;
	logic [8:0]  base;

	// offset to non-negative and estimate the quotient by 360
	always_comb begin
		u     = 17'({~hue[HUE_W-1], hue[HUE_W-2:0]}) + 17'(HUE_BIAS);
		qprod = 33'(u) * 33'(RECIP_360);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1    <= u;
			qhat_s1 <= qprod[RECIP_360_SH +: 8];
		end
	end

	// remainder with one correction step
	always_comb begin
		r0 = 10'(u_s1 - 17'(qhat_s1) * 17'(HUE_RANGE));
		h  = (r0 >= 10'(HUE_RANGE)) ? 9'(r0 - 10'(HUE_RANGE)) : r0[8:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s2 <= h;
		end
	end

	// sector by compare chain
	always_comb begin
		if (h_s2 < 9'(SECTOR_SPAN)) begin
			sec = SEC_0;
		end else if (h_s2 < 9'(2 * SECTOR_SPAN)) begin
			sec = SEC_1;
		end else if (h_s2 < 9'(3 * SECTOR_SPAN)) begin
			sec = SEC_2;
		end else if (h_s2 < 9'(4 * SECTOR_SPAN)) begin
			sec = SEC_3;
		end else if (h_s2 < 9'(5 * SECTOR_SPAN)) begin
			sec = SEC_4;
		end else begin
			sec = SEC_5;
		end
		base = 9'(sec) * 9'(SECTOR_SPAN);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s3 <= sec;
			rem_s3    <= REM_W'(h_s2 - base);
		end
	end

endmodule

[rtl/core/hsv2rgb_chan.sv]
// one colour channel floor(255 * v * (15360 - s * k) / 3932160), three stages
module hsv2rgb_chan import hsv2rgb_pkg::*; (
	input  logic              clk,
	input  logic              adv,
	input  logic [REM_W-1:0]  k,
	input  logic [REG_W-1:0]  sat,
	input  logic [REG_W-1:0]  bri,
	output logic [CHAN_W-1:0] chan_s6
);

	logic [14:0] a_s4;
	logic [15:0] vv_s4;
	logic [30:0] num;
	logic [13:0] y_s5;
	logic [24:0] qprod;

	// scaled weight and scaled brightness
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4  <= 15'(FULL_SCALE) - 15'(15'(sat) * 15'(k));
			vv_s4 <= 16'(bri) * 16'(CHAN_SCALE);
		end
	end

	// full product, drop the q.16 fraction
	always_comb begin
		num = 31'(vv_s4) * 31'(a_s4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s5 <= num[29:16];
		end
	end

	// divide by 60 as a shift by two and a reciprocal multiply for 15
	always_comb begin
		qprod = 25'(y_s5[13:2]) * 25'(RECIP_15);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chan_s6 <= qprod[23:16];
		end
	end

endmodule
